FILE: sv/blg_pkg.sv
// ----------------------------------------------------------------------------
// blg_pkg
// Shared types and constants of the Bresenham line generator.
// ----------------------------------------------------------------------------
package blg_pkg;

   // Coordinate width of every endpoint and pixel
   localparam int COORD_BITS  = 10;
   // Major delta and twice the minor delta need one bit more
   localparam int DELTA_BITS  = COORD_BITS + 1;
   // Signed error term: holds up to three times the major delta
   localparam int ERR_BITS    = DELTA_BITS + 2;
   localparam int COLOR_BITS  = 32;

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [DELTA_BITS-1:0] delta_type;

   // One classified request as it travels from front to back
   typedef struct packed {
      op_type                  op;
      coord_type               major_pos;
      coord_type               major_end;
      coord_type               minor_pos;
      delta_type               major_delta;
      delta_type               minor_increment;
      logic                    minor_down;
      logic                    steep;
      logic [COLOR_BITS-1:0]   color;
   } entry_type;

endpackage

FILE: sv/blg_front.sv
// ----------------------------------------------------------------------------
// blg_front
// Accept requests, classify them and prepare the walk set-up of a load.
// ----------------------------------------------------------------------------
module blg_front (
   input  logic                           req_valid,
   input  logic                           req_operation,
   input  logic [blg_pkg::COORD_BITS-1:0] req_start_x,
   input  logic [blg_pkg::COORD_BITS-1:0] req_start_y,
   input  logic [blg_pkg::COORD_BITS-1:0] req_end_x,
   input  logic [blg_pkg::COORD_BITS-1:0] req_end_y,
   input  logic [blg_pkg::COLOR_BITS-1:0] req_line_color,
   input  logic                           queue_full,
   output logic                           req_stall,
   output logic                           push,
   output blg_pkg::entry_type             push_entry
);

   blg_pkg::coord_type abs_dx;
   blg_pkg::coord_type abs_dy;
   blg_pkg::coord_type min_diff;
   blg_pkg::coord_type ma;
   blg_pkg::coord_type mb;
   blg_pkg::coord_type mi;
   blg_pkg::coord_type nb;
   blg_pkg::coord_type lo_major;
   blg_pkg::coord_type hi_major;
   blg_pkg::coord_type lo_minor;
   blg_pkg::coord_type hi_minor;
   logic               steep;
   logic               swap;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      abs_dx = (req_start_x >= req_end_x) ? req_start_x - req_end_x : req_end_x - req_start_x;
      abs_dy = (req_start_y >= req_end_y) ? req_start_y - req_end_y : req_end_y - req_start_y;
      // slope of exactly one keeps x as the major axis
      steep  = abs_dx < abs_dy;

      if (steep) begin
         ma = req_start_y;
         mi = req_start_x;
         mb = req_end_y;
         nb = req_end_x;
      end else begin
         ma = req_start_x;
         mi = req_start_y;
         mb = req_end_x;
         nb = req_end_y;
      end

      // order the endpoints so the walk runs upward along the major axis
      swap     = ma > mb;
      lo_major = swap ? mb : ma;
      hi_major = swap ? ma : mb;
      lo_minor = swap ? nb : mi;
      hi_minor = swap ? mi : nb;
      min_diff = (hi_minor >= lo_minor) ? hi_minor - lo_minor : lo_minor - hi_minor;

      push_entry.op              = blg_pkg::op_type'(req_operation);
      push_entry.major_pos       = lo_major;
      push_entry.major_end       = hi_major;
      push_entry.minor_pos       = lo_minor;
      push_entry.major_delta     = {1'b0, hi_major - lo_major};
      push_entry.minor_increment = {min_diff, 1'b0};
      push_entry.minor_down      = hi_minor < lo_minor;
      push_entry.steep           = steep;
      push_entry.color           = req_line_color;
   end

endmodule

FILE: sv/blg_queue.sv
// ----------------------------------------------------------------------------
// blg_queue
// Short request queue that decouples the front from the pixel walker.
// ----------------------------------------------------------------------------
module blg_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  blg_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output blg_pkg::entry_type head_entry
);

   blg_pkg::entry_type               slot_ff [blg_pkg::QUEUE_DEPTH];
   logic [blg_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [blg_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [blg_pkg::QCNT_BITS-1:0]    count_ff, count_in;

   assign full       = count_ff == blg_pkg::QCNT_BITS'(blg_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("request pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> !pop)
      else $error("request popped from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= blg_pkg::QCNT_BITS'(blg_pkg::QUEUE_DEPTH))
      else $error("queue count beyond its depth");

endmodule

FILE: sv/blg_back.sv
// ----------------------------------------------------------------------------
// blg_back
// Pixel walker: apply loads, step the error term and register each pixel.
// ----------------------------------------------------------------------------
module blg_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  blg_pkg::entry_type             head_entry,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [blg_pkg::COORD_BITS-1:0] rsp_pixel_x,
   output logic [blg_pkg::COORD_BITS-1:0] rsp_pixel_y,
   output logic [blg_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   output logic                           rsp_last_pixel
);

   blg_pkg::coord_type                 major_pos_ff, major_pos_in;
   blg_pkg::coord_type                 major_end_ff, major_end_in;
   blg_pkg::coord_type                 minor_pos_ff, minor_pos_in;
   logic signed [blg_pkg::ERR_BITS-1:0] error_acc_ff, error_acc_in;
   blg_pkg::delta_type                 major_delta_ff, major_delta_in;
   blg_pkg::delta_type                 minor_inc_ff, minor_inc_in;
   logic                               minor_down_ff, minor_down_in;
   logic                               steep_ff, steep_in;
   logic                               busy_ff, busy_in;
   logic [blg_pkg::COLOR_BITS-1:0]     color_ff, color_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   blg_pkg::coord_type                 rsp_x_ff, rsp_y_ff;
   logic [blg_pkg::COLOR_BITS-1:0]     rsp_color_ff;
   logic                               rsp_last_ff;

   logic                               head_is_load;
   logic                               out_free;
   logic                               emit;
   logic                               last;
   logic signed [blg_pkg::ERR_BITS-1:0] err_sum;
   logic signed [blg_pkg::ERR_BITS-1:0] delta_ext;
   logic signed [blg_pkg::ERR_BITS-1:0] twice_delta;

   assign head_is_load = head_entry.op == blg_pkg::OP_LOAD;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   // a step while idle is dropped without taking the output
   assign pop          = head_valid && (head_is_load || !busy_ff || out_free);
   assign emit         = head_valid && !head_is_load && busy_ff && out_free;
   assign last         = major_pos_ff == major_end_ff;

   assign err_sum     = error_acc_ff + $signed({2'b00, minor_inc_ff});
   assign delta_ext   = $signed({2'b00, major_delta_ff});
   assign twice_delta = $signed({1'b0, major_delta_ff, 1'b0});

   always_comb begin
      major_pos_in   = major_pos_ff;
      major_end_in   = major_end_ff;
      minor_pos_in   = minor_pos_ff;
      error_acc_in   = error_acc_ff;
      major_delta_in = major_delta_ff;
      minor_inc_in   = minor_inc_ff;
      minor_down_in  = minor_down_ff;
      steep_in       = steep_ff;
      busy_in        = busy_ff;
      color_in       = color_ff;
      priority if (head_valid && head_is_load) begin
         major_pos_in   = head_entry.major_pos;
         major_end_in   = head_entry.major_end;
         minor_pos_in   = head_entry.minor_pos;
         error_acc_in   = '0;
         major_delta_in = head_entry.major_delta;
         minor_inc_in   = head_entry.minor_increment;
         minor_down_in  = head_entry.minor_down;
         steep_in       = head_entry.steep;
         busy_in        = 1'b1;
         color_in       = head_entry.color;
      end else if (emit && last) begin
         busy_in = 1'b0;
      end else if (emit) begin
         major_pos_in = major_pos_ff + 1'b1;
         if (err_sum > delta_ext) begin
            minor_pos_in = minor_down_ff ? minor_pos_ff - 1'b1 : minor_pos_ff + 1'b1;
            error_acc_in = err_sum - twice_delta;
         end else begin
            error_acc_in = err_sum;
         end
      end else begin
         // hold the walk state
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      major_pos_ff   <= major_pos_in;
      major_end_ff   <= major_end_in;
      minor_pos_ff   <= minor_pos_in;
      error_acc_ff   <= error_acc_in;
      major_delta_ff <= major_delta_in;
      minor_inc_ff   <= minor_inc_in;
      minor_down_ff  <= minor_down_in;
      steep_ff       <= steep_in;
      color_ff       <= color_in;
      if (emit) begin
         rsp_x_ff     <= steep_ff ? minor_pos_ff : major_pos_ff;
         rsp_y_ff     <= steep_ff ? major_pos_ff : minor_pos_ff;
         rsp_color_ff <= color_ff;
         rsp_last_ff  <= last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_last_pixel  = rsp_last_ff;

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> major_pos_ff <= major_end_ff)
      else $error("major position ran past the line end");

   a_error_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> error_acc_ff <= delta_ext)
      else $error("error term above the major delta");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (emit && last) |=> !busy_ff)
      else $error("walker still busy after the final pixel");

   a_emit_needs_pop: assert property (@(posedge clock) disable iff (reset)
      emit |-> pop)
      else $error("pixel emitted without consuming its request");

endmodule

FILE: sv/bresenham_line_generator_top.sv
// ----------------------------------------------------------------------------
// bresenham_line_generator_top
// Integer Bresenham line walker: load a segment, then step out one pixel
// per step request, swapped back to (x, y) for steep lines.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  req_     in         req_valid/req_stall  operation, endpoints, line colour
//  rsp_     out        rsp_valid/rsp_stall  pixel x/y, colour, last flag
//
//  One request per cycle sustained while req_stall is low; a pixel reaches rsp_ after
//  its step request is taken, passing through the queue and then the output register.
//  Reset is synchronous and active high; it empties the queue and idles the walker.
//  req_stall rises only when the two-entry request queue is full.
//  rsp_stall holds the output register; loads and idle steps still drain.
//
module bresenham_line_generator_top (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic [blg_pkg::COORD_BITS-1:0] req_start_x,
   input  logic [blg_pkg::COORD_BITS-1:0] req_start_y,
   input  logic [blg_pkg::COORD_BITS-1:0] req_end_x,
   input  logic [blg_pkg::COORD_BITS-1:0] req_end_y,
   input  logic [blg_pkg::COLOR_BITS-1:0] req_line_color,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [blg_pkg::COORD_BITS-1:0] rsp_pixel_x,
   output logic [blg_pkg::COORD_BITS-1:0] rsp_pixel_y,
   output logic [blg_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   output logic                           rsp_last_pixel
);

   // front to queue
   logic               push;
   logic               queue_full;
   blg_pkg::entry_type push_entry;

   // queue to back
   logic               pop;
   logic               head_valid;
   blg_pkg::entry_type head_entry;

   // Front: classify each request; on a load, pick the major axis and
   // order the endpoints so the walk always counts upward.
   blg_front u_front (
      .req_valid      (req_valid),
      .req_operation  (req_operation),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_line_color (req_line_color),
      .queue_full     (queue_full),
      .req_stall      (req_stall),
      .push           (push),
      .push_entry     (push_entry)
   );

   // Queue: hold prepared requests while the output side stalls.
   blg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Back: restart the walk on a load, drop a step while idle, and
   // otherwise register one pixel and, before the last one, advance the error term.
   blg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule
